// ----- hw/rtl/bsr_pkg.sv -----
// shared types and constants for the bmp stream to rgba decoder
package bsr_pkg;

    // header byte positions, each the last byte of its little-endian field
    localparam logic [31:0] POS_OFFSET_END = 32'd13;
    localparam logic [31:0] POS_WIDTH_END  = 32'd21;
    localparam logic [31:0] POS_HEIGHT_END = 32'd25;
    localparam logic [31:0] POS_BPP_END    = 32'd29;

    // smallest legal pixel data offset, also the first pixel byte position
    localparam logic [31:0] MIN_DATA_OFFSET = 32'd30;

    // image size limits
    localparam logic [31:0] MAX_WIDTH  = 32'd2048;
    localparam logic [31:0] MAX_HEIGHT = 32'd2048;

    // bits per pixel divided by eight that selects three byte pixels
    localparam logic [12:0] BYTES_PER_PIXEL_24 = 13'd3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // one input transaction as it sits in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] file_byte;
        logic       start_of_file;
    } bsr_in_t;

    // one result item
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [10:0] pixel_column;
        logic [10:0] pixel_line;
        logic [11:0] image_width;
        logic [11:0] image_height;
        logic        last_pixel;
        logic        format_error;
    } bsr_result_t;

endpackage

// ----- hw/rtl/bmp_stream_to_rgba_unit.sv -----
// top level of the bmp byte stream to rgba pixel decoder
//
//  channel   dir  data                                   side
//  s_        in   tdata file_byte, tuser start_of_file    bmp bytes
//  m_        out  tdata rgba/column/line/size, tlast      pixels
//                 last_pixel, tuser format_error
//
// one byte is taken every clock unless a stalled result holds it; a result enters
// the result register as its byte leaves the input register (the parser lies
// between the two registers); the parser state loop sets the byte rate
// aresetn clears the parser; the first byte after reset counts as byte 0
// a stall on m_tready holds the result and stops the input register in turn
module bmp_stream_to_rgba_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // file_byte
    input  logic        s_tuser,   // start_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // red, green, blue, alpha, pixel_column,
                                   // pixel_line, image_width, image_height, zero pad
    output logic        m_tlast,   // last_pixel
    output logic        m_tuser    // format_error
);

    bsr_pkg::bsr_in_t     in_beat;
    bsr_pkg::bsr_result_t res;
    logic                 res_valid;
    logic                 out_ready;
    logic                 advance;

    // the held byte is consumed when the result register can take its result
    assign advance = in_beat.valid && out_ready;

    bsr_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (advance),
        .in_beat  (in_beat)
    );

    bsr_decode u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_beat   (in_beat),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res)
    );

    bsr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // input only backs up behind a stalled result
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a stalled result");

    // an error transaction carries no pixel content
    a_error_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 80'd0 && !m_tlast))
        else $error("error transaction carries pixel fields");

    // pixel coordinates stay inside the header size
    a_coord_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |->
        ({1'b0, m_tdata[42:32]} < m_tdata[65:54] &&
         {1'b0, m_tdata[53:43]} < m_tdata[77:66]))
        else $error("pixel coordinate outside image");

endmodule

// ----- hw/rtl/bsr_in_stage.sv -----
// input register for the byte stream
module bsr_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // file_byte
    input  logic           s_tuser,   // start_of_file
    input  logic           advance,
    output bsr_pkg::bsr_in_t in_beat
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       sof_reg;

    // room when empty or when the held byte moves on this cycle
    assign s_tready = !valid_reg || advance;
    assign in_beat  = '{valid: valid_reg, file_byte: byte_reg, start_of_file: sof_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // payload loads without reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            byte_reg <= s_tdata;
            sof_reg  <= s_tuser;
        end
    end

endmodule

// ----- hw/rtl/bsr_decode.sv -----
// header parser and pixel assembler, one byte per cycle while advance is high
module bsr_decode (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bsr_pkg::bsr_in_t     in_beat,
    input  logic                 advance,
    output logic                 res_valid,
    output bsr_pkg::bsr_result_t res
);

    logic [31:0] pos_reg, pos_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] offset_reg, offset_next;
    logic [11:0] width_reg, width_next;
    logic [11:0] height_reg, height_next;
    logic        mode3_reg, mode3_next;
    logic [10:0] col_reg, col_next;
    logic [10:0] row_reg, row_next;
    logic [13:0] rbc_reg, rbc_next;
    logic [23:0] pix_reg, pix_next;
    logic [1:0]  bip_reg, bip_next;
    logic        err_reg, err_next;
    logic        done_reg, done_next;

    always_comb begin
        logic [31:0] cur_pos;
        logic [31:0] cur_shift;
        logic [31:0] cur_offset;
        logic [11:0] cur_width;
        logic [11:0] cur_height;
        logic        cur_mode3;
        logic [10:0] cur_col;
        logic [10:0] cur_row;
        logic [13:0] cur_rbc;
        logic [23:0] cur_pix;
        logic [1:0]  cur_bip;
        logic        cur_err;
        logic        cur_done;
        logic        sof;
        logic [7:0]  b;
        logic [1:0]  bip_top;
        logic [13:0] data_len;
        logic [13:0] row_len;
        logic [13:0] rbc_inc;
        logic [11:0] col_inc;
        logic [11:0] row_inc;
        logic [11:0] line_full;
        logic        last;

        sof = in_beat.start_of_file;
        b   = in_beat.file_byte;

        // a start mark makes the byte see a freshly cleared parser
        cur_pos    = sof ? 32'd0 : pos_reg;
        cur_shift  = sof ? 32'd0 : shift_reg;
        cur_offset = sof ? 32'd0 : offset_reg;
        cur_width  = sof ? 12'd0 : width_reg;
        cur_height = sof ? 12'd0 : height_reg;
        cur_mode3  = sof ? 1'b0  : mode3_reg;
        cur_col    = sof ? 11'd0 : col_reg;
        cur_row    = sof ? 11'd0 : row_reg;
        cur_rbc    = sof ? 14'd0 : rbc_reg;
        cur_pix    = sof ? 24'd0 : pix_reg;
        cur_bip    = sof ? 2'd0  : bip_reg;
        cur_err    = sof ? 1'b0  : err_reg;
        cur_done   = sof ? 1'b0  : done_reg;

        shift_next  = {b, cur_shift[31:8]};
        pos_next    = (cur_pos == 32'hFFFF_FFFF) ? cur_pos : cur_pos + 32'd1;
        offset_next = cur_offset;
        width_next  = cur_width;
        height_next = cur_height;
        mode3_next  = cur_mode3;
        col_next    = cur_col;
        row_next    = cur_row;
        rbc_next    = cur_rbc;
        pix_next    = cur_pix;
        bip_next    = cur_bip;
        err_next    = cur_err;
        done_next   = cur_done;

        // row geometry from the stored header
        bip_top  = cur_mode3 ? 2'd2 : 2'd3;
        data_len = cur_mode3 ? ({1'b0, cur_width, 1'b0} + {2'b00, cur_width})
                             : {cur_width, 2'b00};
        row_len  = (data_len + 14'd3) & ~14'd3;
        rbc_inc  = cur_rbc + 14'd1;
        col_inc  = {1'b0, cur_col} + 12'd1;
        row_inc  = {1'b0, cur_row} + 12'd1;
        last     = (row_inc == cur_height) && (col_inc == cur_width);
        line_full = cur_height - 12'd1 - {1'b0, cur_row};

        res_valid = 1'b0;
        res       = '0;

        if (cur_pos == bsr_pkg::POS_OFFSET_END) begin
            offset_next = shift_next;
            if (shift_next < bsr_pkg::MIN_DATA_OFFSET) begin
                err_next = 1'b1;
            end
        end else if (cur_pos == bsr_pkg::POS_WIDTH_END) begin
            width_next = shift_next[11:0];
            if (shift_next == 32'd0 || shift_next > bsr_pkg::MAX_WIDTH) begin
                err_next = 1'b1;
            end
        end else if (cur_pos == bsr_pkg::POS_HEIGHT_END) begin
            height_next = shift_next[11:0];
            if (shift_next == 32'd0 || shift_next > bsr_pkg::MAX_HEIGHT) begin
                err_next = 1'b1;
            end
        end else if (cur_pos == bsr_pkg::POS_BPP_END) begin
            // bits per pixel in the upper half, divided by eight
            mode3_next = (shift_next[31:19] == bsr_pkg::BYTES_PER_PIXEL_24);
            if (cur_err) begin
                res_valid        = 1'b1;
                res.format_error = 1'b1;
            end
        end else if (cur_pos >= bsr_pkg::MIN_DATA_OFFSET && cur_pos >= cur_offset
                     && !cur_err && !cur_done) begin
            // pixel bytes, padding past data_len is skipped
            if (cur_rbc < data_len) begin
                if (cur_bip < bip_top) begin
                    pix_next = cur_pix | ({16'd0, b} << {cur_bip, 3'b000});
                    bip_next = cur_bip + 2'd1;
                end else begin
                    res_valid = 1'b1;
                    res.red   = b;
                    if (cur_mode3) begin
                        res.green = cur_pix[15:8];
                        res.blue  = cur_pix[7:0];
                        res.alpha = bsr_pkg::ALPHA_OPAQUE;
                    end else begin
                        res.green = cur_pix[23:16];
                        res.blue  = cur_pix[15:8];
                        res.alpha = cur_pix[7:0];
                    end
                    res.pixel_column = cur_col;
                    res.pixel_line   = line_full[10:0];
                    res.image_width  = cur_width;
                    res.image_height = cur_height;
                    res.last_pixel   = last;
                    pix_next = 24'd0;
                    bip_next = 2'd0;
                    col_next = col_inc[10:0];
                    if (last) begin
                        done_next = 1'b1;
                    end
                end
            end
            rbc_next = rbc_inc;
            // end of a padded row
            if (rbc_inc >= row_len) begin
                rbc_next = 14'd0;
                col_next = 11'd0;
                bip_next = 2'd0;
                pix_next = 24'd0;
                row_next = row_inc[10:0];
                if (row_inc >= cur_height) begin
                    done_next = 1'b1;
                end
            end
        end
    end

    // parser state, updated once per consumed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            shift_reg  <= '0;
            offset_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            mode3_reg  <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
            rbc_reg    <= '0;
            pix_reg    <= '0;
            bip_reg    <= '0;
            err_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end else if (advance) begin
            pos_reg    <= pos_next;
            shift_reg  <= shift_next;
            offset_reg <= offset_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            mode3_reg  <= mode3_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            rbc_reg    <= rbc_next;
            pix_reg    <= pix_next;
            bip_reg    <= bip_next;
            err_reg    <= err_next;
            done_reg   <= done_next;
        end
    end

endmodule

// ----- hw/rtl/bsr_out_stage.sv -----
// result register toward the pixel stream
module bsr_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic                 res_valid,
    input  bsr_pkg::bsr_result_t res,
    output logic                 out_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [79:0]          m_tdata,   // red, green, blue, alpha, pixel_column,
                                            // pixel_line, image_width, image_height, zero pad
    output logic                 m_tlast,   // last_pixel
    output logic                 m_tuser    // format_error
);

    logic                 valid_reg;
    bsr_pkg::bsr_result_t res_reg;

    // register is free when empty or its transaction completes now
    assign out_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_ready) begin
            valid_reg <= advance && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            res_reg <= res;
        end
    end

    // pack fields from the lowest bit up
    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, res_reg.image_height, res_reg.image_width,
                       res_reg.pixel_line, res_reg.pixel_column, res_reg.alpha,
                       res_reg.blue, res_reg.green, res_reg.red};
    assign m_tlast  = res_reg.last_pixel;
    assign m_tuser  = res_reg.format_error;

endmodule
